### hw/rtl/tlc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tlc_pkg: shared types and constants
// Controller states, access codes, lookup status and default geometry.
// ----------------------------------------------------------------------------
package tlc_pkg;

    localparam int DEF_OFFSET_BITS = 6;
    localparam int DEF_FIRST_SETS  = 64;
    localparam int DEF_FIRST_WAYS  = 4;
    localparam int DEF_SECOND_SETS = 512;
    localparam int DEF_SECOND_WAYS = 8;

    localparam logic ACT_READ  = 1'b0;
    localparam logic ACT_WRITE = 1'b1;

    localparam logic PH_READ = 1'b0;   // L2 lookup for the missing block
    localparam logic PH_WB   = 1'b1;   // L2 lookup for the dirty L1 victim

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_L1,
        S_ISSUE,
        S_L2,
        S_DONE
    } state_t;

    typedef struct packed {
        logic hit;
        logic evict_dirty;
    } lookup_stat_t;

endpackage
`default_nettype wire

### hw/rtl/tlc_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tlc_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module tlc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

### hw/rtl/tlc_lookup.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tlc_lookup: set lookup and update for one cache level
// Tag match, victim choice, LRU touch and fill of one set row.
// ----------------------------------------------------------------------------
module tlc_lookup #(
    parameter int WAYS  = 4,
    parameter int TAG_W = 20,
    localparam int RANK_W = (WAYS > 1) ? $clog2(WAYS) : 1,
    localparam int ROW_W  = WAYS * (TAG_W + 2 + RANK_W)
) (
    input  wire logic [ROW_W-1:0] row,
    input  wire logic [TAG_W-1:0] look_tag,
    input  wire logic             is_write,
    output tlc_pkg::lookup_stat_t stat,
    output logic      [TAG_W-1:0] victim_tag,
    output logic      [ROW_W-1:0] row_new
);

    logic [WAYS-1:0][TAG_W-1:0]  tags, tags_n;
    logic [WAYS-1:0]             vld, vld_n, drt, drt_n;
    logic [WAYS-1:0][RANK_W-1:0] rnk, rnk_n;
    logic                        hit, inv_found;
    logic [RANK_W-1:0]           hway, inv_way, best, vway, way;
    logic [RANK_W:0]             old;

    assign {tags, vld, drt, rnk} = row;
    assign row_new = {tags_n, vld_n, drt_n, rnk_n};

    always_comb
    begin
        hit       = 1'b0;
        hway      = '0;
        inv_found = 1'b0;
        inv_way   = '0;
        best      = '0;
        for (int i = 0; i < WAYS; i++)
        begin
            if (!hit && vld[i] && tags[i] == look_tag)
            begin
                hit  = 1'b1;
                hway = RANK_W'(i);
            end
            if (!inv_found && !vld[i])
            begin
                inv_found = 1'b1;
                inv_way   = RANK_W'(i);
            end
        end
        // all ways valid: highest rank, lowest index on a tie
        for (int i = 1; i < WAYS; i++)
        begin
            if (rnk[i] > rnk[best])
            begin
                best = RANK_W'(i);
            end
        end
        vway = inv_found ? inv_way : best;
        way  = hit ? hway : vway;
        old  = vld[way] ? {1'b0, rnk[way]} : (RANK_W + 1)'(WAYS);

        tags_n = tags;
        vld_n  = vld;
        drt_n  = drt;
        rnk_n  = rnk;
        for (int i = 0; i < WAYS; i++)
        begin
            if (RANK_W'(i) != way && vld[i] && {1'b0, rnk[i]} < old)
            begin
                rnk_n[i] = rnk[i] + 1'b1;
            end
        end
        rnk_n[way] = '0;
        if (hit)
        begin
            drt_n[way] = drt[way] | is_write;
        end
        else
        begin
            vld_n[way]  = 1'b1;
            drt_n[way]  = is_write;
            tags_n[way] = look_tag;
        end

        stat.hit         = hit;
        stat.evict_dirty = !hit && vld[vway] && drt[vway];
        victim_tag       = tags[vway];
    end

endmodule
`default_nettype wire

### hw/rtl/two_level_lru_writeback_cache_tags.sv
`timescale 1ns / 1ps
`default_nettype none
// Sequence: L1 hit S_L1, S_DONE; L1 miss S_L1, S_ISSUE, S_L2, S_DONE; a dirty L1
//   victim adds one more S_ISSUE/S_L2 pass (one more L2 set read-modify-write).
// Throughput: one access in flight; the next is taken only back in S_IDLE, after the
//   L1 set RAM pass and one or two L2 set RAM passes (registered read, then
//   read-modify-write of a whole set row). A stalled result holds S_DONE.
// Reset: async, active low. After reset both set RAMs are swept to zero, one set
//   per cycle until every set of the larger RAM is cleared, with in_ready low.
// ----------------------------------------------------------------------------
// two_level_lru_writeback_cache_tags: two-level LRU write-back tag model
// Tag/valid/dirty/LRU state of an L1 and an L2 set-associative cache, one
// set row per RAM word. Set counts must be powers of two; the block does not check.
// ----------------------------------------------------------------------------
module two_level_lru_writeback_cache_tags #(
    parameter int OFFSET_BITS = tlc_pkg::DEF_OFFSET_BITS,
    parameter int FIRST_SETS  = tlc_pkg::DEF_FIRST_SETS,
    parameter int FIRST_WAYS  = tlc_pkg::DEF_FIRST_WAYS,
    parameter int SECOND_SETS = tlc_pkg::DEF_SECOND_SETS,
    parameter int SECOND_WAYS = tlc_pkg::DEF_SECOND_WAYS
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        action,
    input  wire logic [31:0] address,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             l1_hit,
    output logic             l1_victim_wb,
    output logic             l2_write_hit,
    output logic             l2_read_done,
    output logic             l2_read_hit,
    output logic [1:0]       l2_writebacks
);

    // address split
    localparam int BLK_W   = 32 - OFFSET_BITS;
    localparam int S1_BITS = $clog2(FIRST_SETS);
    localparam int S2_BITS = $clog2(SECOND_SETS);
    localparam int SI1_W   = (S1_BITS > 0) ? S1_BITS : 1;
    localparam int SI2_W   = (S2_BITS > 0) ? S2_BITS : 1;
    localparam int T1_W    = BLK_W - S1_BITS;
    localparam int T2_W    = BLK_W - S2_BITS;
    localparam int R1_W    = (FIRST_WAYS > 1) ? $clog2(FIRST_WAYS) : 1;
    localparam int R2_W    = (SECOND_WAYS > 1) ? $clog2(SECOND_WAYS) : 1;
    localparam int ROW1_W  = FIRST_WAYS * (T1_W + 2 + R1_W);
    localparam int ROW2_W  = SECOND_WAYS * (T2_W + 2 + R2_W);
    localparam int MAXS    = (FIRST_SETS > SECOND_SETS) ? FIRST_SETS : SECOND_SETS;
    localparam int CW      = (MAXS > 1) ? $clog2(MAXS) : 1;

    tlc_pkg::state_t state_reg, state_next;

    logic [CW-1:0]    clr_cnt_reg, clr_cnt_next;
    logic             act_reg, act_next;
    logic [BLK_W-1:0] blk_reg, blk_next;
    logic [BLK_W-1:0] l2_blk_reg, l2_blk_next;
    logic             phase_reg, phase_next;
    logic             hit_reg, hit_next;
    logic             wb_reg, wb_next;
    logic             wbhit_reg, wbhit_next;
    logic             rdhit_reg, rdhit_next;
    logic [1:0]       evict_reg, evict_next;
    logic             out_valid_reg, out_valid_next;
    logic             res_hit_reg, res_wb_reg, res_wbhit_reg, res_rdhit_reg;
    logic [1:0]       res_evict_reg;

    logic [BLK_W-1:0] in_blk;
    logic [SI1_W-1:0] l1_raddr, l1_waddr;
    logic [SI2_W-1:0] l2_raddr, l2_waddr;
    logic             l1_we, l2_we;
    logic [ROW1_W-1:0] l1_rdata, l1_wdata, l1_row_new;
    logic [ROW2_W-1:0] l2_rdata, l2_wdata, l2_row_new;
    tlc_pkg::lookup_stat_t l1_stat, l2_stat;
    logic [T1_W-1:0]  l1_vtag;
    logic [T2_W-1:0]  l2_vtag;
    logic [BLK_W-1:0] vblk;
    logic             accept, deliver, clr_last;

    assign in_blk   = address[31:OFFSET_BITS];
    assign accept   = in_valid && in_ready;
    assign deliver  = (state_reg == tlc_pkg::S_DONE) && (!out_valid_reg || out_ready);
    assign clr_last = clr_cnt_reg == CW'(MAXS - 1);

    // L1 is read every idle cycle at the incoming set; data is used in S_L1.
    assign l1_raddr = SI1_W'(in_blk % FIRST_SETS);
    // L2 is read at the set of the pending L2 block; data is used in S_L2.
    assign l2_raddr = SI2_W'(l2_blk_reg % SECOND_SETS);
    // dirty L1 victim's block address
    assign vblk = (BLK_W'(l1_vtag) << S1_BITS) | BLK_W'(blk_reg % FIRST_SETS);

    tlc_ram #(.WIDTH(ROW1_W), .DEPTH(FIRST_SETS)) u_l1_ram (
        .clk   (clk),
        .we    (l1_we),
        .waddr (l1_waddr),
        .wdata (l1_wdata),
        .raddr (l1_raddr),
        .rdata (l1_rdata)
    );

    tlc_ram #(.WIDTH(ROW2_W), .DEPTH(SECOND_SETS)) u_l2_ram (
        .clk   (clk),
        .we    (l2_we),
        .waddr (l2_waddr),
        .wdata (l2_wdata),
        .raddr (l2_raddr),
        .rdata (l2_rdata)
    );

    tlc_lookup #(.WAYS(FIRST_WAYS), .TAG_W(T1_W)) u_l1_lookup (
        .row        (l1_rdata),
        .look_tag   (T1_W'(blk_reg >> S1_BITS)),
        .is_write   (act_reg == tlc_pkg::ACT_WRITE),
        .stat       (l1_stat),
        .victim_tag (l1_vtag),
        .row_new    (l1_row_new)
    );

    // write-back lookup marks dirty; the read lookup does not
    tlc_lookup #(.WAYS(SECOND_WAYS), .TAG_W(T2_W)) u_l2_lookup (
        .row        (l2_rdata),
        .look_tag   (T2_W'(l2_blk_reg >> S2_BITS)),
        .is_write   (phase_reg == tlc_pkg::PH_WB),
        .stat       (l2_stat),
        .victim_tag (l2_vtag),
        .row_new    (l2_row_new)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tlc_pkg::S_CLEAR: if (clr_last) state_next = tlc_pkg::S_IDLE;
            tlc_pkg::S_IDLE:  if (accept) state_next = tlc_pkg::S_L1;
            tlc_pkg::S_L1:    state_next = l1_stat.hit ? tlc_pkg::S_DONE : tlc_pkg::S_ISSUE;
            tlc_pkg::S_ISSUE: state_next = tlc_pkg::S_L2;
            tlc_pkg::S_L2:    state_next = (phase_reg == tlc_pkg::PH_WB) ? tlc_pkg::S_ISSUE
                                                                         : tlc_pkg::S_DONE;
            tlc_pkg::S_DONE:  if (deliver) state_next = tlc_pkg::S_IDLE;
            default:          state_next = tlc_pkg::S_CLEAR;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        in_ready       = state_reg == tlc_pkg::S_IDLE;
        clr_cnt_next   = clr_cnt_reg;
        act_next       = act_reg;
        blk_next       = blk_reg;
        l2_blk_next    = l2_blk_reg;
        phase_next     = phase_reg;
        hit_next       = hit_reg;
        wb_next        = wb_reg;
        wbhit_next     = wbhit_reg;
        rdhit_next     = rdhit_reg;
        evict_next     = evict_reg;
        out_valid_next = out_valid_reg;
        l1_we          = 1'b0;
        l1_waddr       = SI1_W'(blk_reg % FIRST_SETS);
        l1_wdata       = l1_row_new;
        l2_we          = 1'b0;
        l2_waddr       = l2_raddr;
        l2_wdata       = l2_row_new;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            tlc_pkg::S_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                l1_we    = {1'b0, clr_cnt_reg} < (CW + 1)'(FIRST_SETS);
                l1_waddr = SI1_W'(clr_cnt_reg);
                l1_wdata = '0;
                l2_we    = {1'b0, clr_cnt_reg} < (CW + 1)'(SECOND_SETS);
                l2_waddr = SI2_W'(clr_cnt_reg);
                l2_wdata = '0;
            end
            tlc_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    act_next = action;
                    blk_next = in_blk;
                end
            end
            tlc_pkg::S_L1:
            begin
                l1_we      = 1'b1;
                hit_next   = l1_stat.hit;
                wb_next    = l1_stat.evict_dirty;
                wbhit_next = 1'b0;
                rdhit_next = 1'b0;
                evict_next = '0;
                if (l1_stat.evict_dirty)
                begin
                    phase_next  = tlc_pkg::PH_WB;
                    l2_blk_next = vblk;
                end
                else
                begin
                    phase_next  = tlc_pkg::PH_READ;
                    l2_blk_next = blk_reg;
                end
            end
            tlc_pkg::S_ISSUE:
            begin
                // L2 read address settles from l2_blk_reg
            end
            tlc_pkg::S_L2:
            begin
                l2_we      = 1'b1;
                evict_next = evict_reg + 2'(l2_stat.evict_dirty);
                if (phase_reg == tlc_pkg::PH_WB)
                begin
                    wbhit_next  = l2_stat.hit;
                    phase_next  = tlc_pkg::PH_READ;
                    l2_blk_next = blk_reg;
                end
                else
                begin
                    rdhit_next = l2_stat.hit;
                end
            end
            tlc_pkg::S_DONE:
            begin
                if (deliver)
                begin
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tlc_pkg::S_CLEAR;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg    <= act_next;
        blk_reg    <= blk_next;
        l2_blk_reg <= l2_blk_next;
        phase_reg  <= phase_next;
        hit_reg    <= hit_next;
        wb_reg     <= wb_next;
        wbhit_reg  <= wbhit_next;
        rdhit_reg  <= rdhit_next;
        evict_reg  <= evict_next;
        if (deliver)
        begin
            res_hit_reg   <= hit_reg;
            res_wb_reg    <= wb_reg;
            res_wbhit_reg <= wbhit_reg;
            res_rdhit_reg <= rdhit_reg;
            res_evict_reg <= evict_reg;
        end
    end

    // result beat
    assign out_valid     = out_valid_reg;
    assign l1_hit        = res_hit_reg;
    assign l1_victim_wb  = res_wb_reg;
    assign l2_write_hit  = res_wbhit_reg;
    assign l2_read_done  = !res_hit_reg;
    assign l2_read_hit   = res_rdhit_reg;
    assign l2_writebacks = res_evict_reg;

`ifndef SYNTH
    a_rise_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == tlc_pkg::S_DONE)
        else $error("result beat not issued from S_DONE");

    a_wbhit_needs_wb: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (!l2_write_hit || l1_victim_wb))
        else $error("L2 write hit without L1 write-back");

    a_hit_no_l2: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && l1_hit |-> !l1_victim_wb && !l2_read_hit && l2_writebacks == 2'd0)
        else $error("L1 hit reported L2 activity");

    a_evict_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == tlc_pkg::S_L2 |-> evict_reg != 2'd2 && evict_reg != 2'd3)
        else $error("L2 eviction count overflow");
`endif

endmodule
`default_nettype wire

### tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench for the two-level LRU write-back cache tag model
// Drives read and write accesses through a valid/ready port, keeps its own
// copy of both cache levels' tag, valid, dirty and LRU state, and checks the
// per-access event flags of every result beat in order.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int OFS  = tlc_pkg::DEF_OFFSET_BITS;
    localparam int S1   = tlc_pkg::DEF_FIRST_SETS;
    localparam int W1   = tlc_pkg::DEF_FIRST_WAYS;
    localparam int S2   = tlc_pkg::DEF_SECOND_SETS;
    localparam int W2   = tlc_pkg::DEF_SECOND_WAYS;
    localparam int N_RANDOM    = 1130;
    localparam int CYCLE_LIMIT = 200000;

    typedef struct {
        logic        act;
        logic [31:0] addr;
    } access_t;

    typedef struct {
        logic       hit;
        logic       wb;
        logic       wb_hit;
        logic       rd;
        logic       rd_hit;
        logic [1:0] l2_wbs;
    } flags_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic        action;
    logic [31:0] address;
    logic        out_valid;
    logic        out_ready;
    logic        l1_hit;
    logic        l1_victim_wb;
    logic        l2_write_hit;
    logic        l2_read_done;
    logic        l2_read_hit;
    logic [1:0]  l2_writebacks;

    two_level_lru_writeback_cache_tags u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .action       (action),
        .address      (address),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .l1_hit       (l1_hit),
        .l1_victim_wb (l1_victim_wb),
        .l2_write_hit (l2_write_hit),
        .l2_read_done (l2_read_done),
        .l2_read_hit  (l2_read_hit),
        .l2_writebacks(l2_writebacks)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // Shadow copy of both tag arrays, indexed [set][way]
    logic [31:0] l1_tag [S1][W1];
    logic        l1_vld [S1][W1];
    logic        l1_drt [S1][W1];
    int          l1_age [S1][W1];
    logic [31:0] l2_tag [S2][W2];
    logic        l2_vld [S2][W2];
    logic        l2_drt [S2][W2];
    int          l2_age [S2][W2];

    access_t pending_accesses[$];
    flags_t  expected_flags[$];
    int      errors;
    int      n_sent;
    int      n_checked;
    int      n_l1_hits;
    int      n_l1_wbs;
    int      n_l2_wbs;
    bit      stim_done;
    bit      quiet;       // no idling in the last stretch
    int      cycles;

    // Sampled handshake state and idle-burst counters
    logic in_ready_q;
    int   idle_in;
    int   idle_out;

    // Move a way to most recent; ways below its old rank age by one.
    function automatic void l1_touch(int s, int w);
        int old;
        old = l1_vld[s][w] ? l1_age[s][w] : W1;
        for (int i = 0; i < W1; i++)
            if (i != w && l1_vld[s][i] && l1_age[s][i] < old)
                l1_age[s][i]++;
        l1_age[s][w] = 0;
    endfunction

    function automatic void l2_touch(int s, int w);
        int old;
        old = l2_vld[s][w] ? l2_age[s][w] : W2;
        for (int i = 0; i < W2; i++)
            if (i != w && l2_vld[s][i] && l2_age[s][i] < old)
                l2_age[s][i]++;
        l2_age[s][w] = 0;
    endfunction

    // One L2 lookup; returns hit, bumps the dirty eviction count when a miss evicts a dirty way.
    function automatic logic l2_lookup(logic [31:0] blk, logic is_wr, inout int evs);
        int s;
        int w;
        logic [31:0] t;
        s = blk % S2;
        t = blk / S2;
        for (int i = 0; i < W2; i++)
            if (l2_vld[s][i] && l2_tag[s][i] == t)
            begin
                l2_touch(s, i);
                if (is_wr)
                    l2_drt[s][i] = 1'b1;
                return 1'b1;
            end
        w = -1;
        for (int i = 0; i < W2 && w < 0; i++)
            if (!l2_vld[s][i])
                w = i;
        if (w < 0)
        begin
            w = 0;
            for (int i = 1; i < W2; i++)
                if (l2_age[s][i] > l2_age[s][w])
                    w = i;
        end
        if (l2_vld[s][w] && l2_drt[s][w])
            evs++;
        l2_touch(s, w);
        l2_vld[s][w] = 1'b1;
        l2_drt[s][w] = is_wr;
        l2_tag[s][w] = t;
        return 1'b0;
    endfunction

    function automatic flags_t cache_access(access_t a);
        flags_t f;
        logic [31:0] blk;
        int s;
        int w;
        int evs;
        logic [31:0] t;
        f = '{default: 1'b0};
        evs = 0;
        blk = a.addr >> OFS;
        s = blk % S1;
        t = blk / S1;
        w = -1;
        for (int i = 0; i < W1 && w < 0; i++)
            if (l1_vld[s][i] && l1_tag[s][i] == t)
                w = i;
        if (w >= 0)
        begin
            f.hit = 1'b1;
            l1_touch(s, w);
            if (a.act == tlc_pkg::ACT_WRITE)
                l1_drt[s][w] = 1'b1;
        end
        else
        begin
            for (int i = 0; i < W1 && w < 0; i++)
                if (!l1_vld[s][i])
                    w = i;
            if (w < 0)
            begin
                w = 0;
                for (int i = 1; i < W1; i++)
                    if (l1_age[s][i] > l1_age[s][w])
                        w = i;
            end
            if (l1_vld[s][w] && l1_drt[s][w])
            begin
                f.wb = 1'b1;
                f.wb_hit = l2_lookup(l1_tag[s][w] * S1 + s, 1'b1, evs);
            end
            l1_touch(s, w);
            l1_vld[s][w] = 1'b1;
            l1_drt[s][w] = (a.act == tlc_pkg::ACT_WRITE);
            l1_tag[s][w] = t;
            f.rd = 1'b1;
            f.rd_hit = l2_lookup(blk, 1'b0, evs);
        end
        f.l2_wbs = evs[1:0];
        return f;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch beat %0d: %s got %0d expected %0d", n_checked, what, got, want);
        errors++;
    endtask

    task automatic push_access(logic act, logic [31:0] addr);
        access_t a;
        a.act = act;
        a.addr = addr;
        pending_accesses.push_back(a);
    endtask

    // Random access. Mostly a small working set of tags mapped onto a few
    // sets so L1 and L2 both fill up and evict; the rest is low-address traffic or wide noise.
    task automatic push_random();
        logic [31:0] addr;
        int kind;
        kind = $urandom_range(0, 9);
        if (kind < 7)
        begin
            // L2 set index bits [14:6]; tag choice in [31:15] crowds 8 ways
            addr = 32'($urandom_range(0, 11) * 7919) << 15;
            addr[14:6] = 9'($urandom_range(0, 3) * 64 + $urandom_range(0, 1));
            addr[5:0] = 6'($urandom);
        end
        else if (kind < 9)
            addr = {18'd0, 6'($urandom_range(0, 40)), 2'($urandom_range(0, 3)),
                    6'($urandom)};
        else
            addr = $urandom;
        push_access(1'($urandom_range(0, 1)), addr);
    endtask

    // Stimulus
    initial
    begin
        errors = 0;
        n_sent = 0;
        n_checked = 0;
        n_l1_hits = 0;
        n_l1_wbs = 0;
        n_l2_wbs = 0;
        stim_done = 0;
        quiet = 0;
        for (int s = 0; s < S1; s++)
            for (int w = 0; w < W1; w++)
            begin
                l1_vld[s][w] = 0;
                l1_drt[s][w] = 0;
                l1_age[s][w] = 0;
                l1_tag[s][w] = 0;
            end
        for (int s = 0; s < S2; s++)
            for (int w = 0; w < W2; w++)
            begin
                l2_vld[s][w] = 0;
                l2_drt[s][w] = 0;
                l2_age[s][w] = 0;
                l2_tag[s][w] = 0;
            end

        // Directed: address extremes, read and write, then six dirty writes
        // into L1 set 0 (four ways) to force LRU victims, write-backs and
        // L2 allocation of dirty lines; rereads hit and reuse after eviction.
        push_access(tlc_pkg::ACT_READ, 32'h0000_0000);
        push_access(tlc_pkg::ACT_WRITE, 32'hFFFF_FFFF);
        push_access(tlc_pkg::ACT_WRITE, 32'h0000_003F);
        push_access(tlc_pkg::ACT_READ, 32'hFFFF_FFC0);
        for (int i = 1; i <= 6; i++)
            push_access(tlc_pkg::ACT_WRITE, 32'(i) << 12);
        push_access(tlc_pkg::ACT_READ, 32'h0000_5000);
        push_access(tlc_pkg::ACT_READ, 32'h0000_1000);
        push_access(tlc_pkg::ACT_WRITE, 32'h0000_2000);
        // Same L2 set (bits 14:6 zero), ten tags: overflows 8 ways, dirty
        // L1 victims chain into dirty L2 evictions.
        for (int i = 1; i <= 10; i++)
            push_access(tlc_pkg::ACT_WRITE, 32'(i) << 15);
        push_access(tlc_pkg::ACT_READ, 32'hAAAA_AAAA);
        push_access(tlc_pkg::ACT_READ, 32'h5555_5555);
        for (int i = 0; i < N_RANDOM; i++)
            push_random();
        stim_done = 1;
    end

    // Driver: inputs change on the falling edge
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            action <= 1'b0;
            address <= '0;
        end
        else if (!in_valid || in_ready_q)
        begin
            if (pending_accesses.size() != 0 && (quiet || $urandom_range(0, 5) != 0)
                && idle_in == 0)
            begin
                access_t a;
                a = pending_accesses.pop_front();
                in_valid <= 1'b1;
                action <= a.act;
                address <= a.addr;
                expected_flags.push_back(cache_access(a));
                n_sent++;
            end
            else
                in_valid <= 1'b0;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ready_q <= 1'b0;
            idle_in <= 0;
        end
        else
        begin
            in_ready_q <= in_valid && in_ready;
            if (quiet)
                idle_in <= 0;
            else if (idle_in > 0)
                idle_in <= idle_in - 1;
            else if ($urandom_range(0, 9) == 0)
                idle_in <= $urandom_range(1, 5);
        end
    end

    // Receiver stall, changed on the falling edge
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            idle_out <= 0;
        end
        else if (idle_out > 0)
        begin
            out_ready <= 1'b0;
            idle_out <= idle_out - 1;
        end
        else if (!quiet && $urandom_range(0, 7) == 0)
        begin
            out_ready <= 1'b0;
            idle_out <= $urandom_range(0, 4);
        end
        else
            out_ready <= 1'b1;
    end

    // Monitor: compare each result beat with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_flags.size() == 0)
            begin
                report_mismatch("unexpected result beat", 1, 0);
            end
            else
            begin
                flags_t e;
                e = expected_flags.pop_front();
                if (l1_hit !== e.hit)
                    report_mismatch("l1_hit", l1_hit, e.hit);
                if (l1_victim_wb !== e.wb)
                    report_mismatch("l1_victim_wb", l1_victim_wb, e.wb);
                if (l2_write_hit !== e.wb_hit)
                    report_mismatch("l2_write_hit", l2_write_hit, e.wb_hit);
                if (l2_read_done !== e.rd)
                    report_mismatch("l2_read_done", l2_read_done, e.rd);
                if (l2_read_hit !== e.rd_hit)
                    report_mismatch("l2_read_hit", l2_read_hit, e.rd_hit);
                if (l2_writebacks !== e.l2_wbs)
                    report_mismatch("l2_writebacks", l2_writebacks, e.l2_wbs);
                n_l1_hits += e.hit;
                n_l1_wbs += e.wb;
                n_l2_wbs += e.l2_wbs;
            end
            n_checked++;
        end
    end

    // Reset, end of run and timeout
    initial
    begin
        rst_n = 1'b0;
        cycles = 0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        while (!(stim_done && pending_accesses.size() == 0 && !in_valid
                 && expected_flags.size() == 0) && cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
            if (stim_done && pending_accesses.size() < 100)
                quiet = 1;
        end
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout with %0d results outstanding", expected_flags.size());
            $display("simulation failed");
        end
        else
        begin
            repeat (20) @(posedge clk);
            $display("%0d accesses sent, %0d checked: %0d L1 hits, %0d L1 write-backs,",
                     n_sent, n_checked, n_l1_hits, n_l1_wbs);
            $display("%0d dirty L2 evictions, %0d mismatches", n_l2_wbs, errors);
            if (errors == 0 && expected_flags.size() == 0)
                $display("simulation ok");
            else
                $display("simulation failed");
        end
        $finish;
    end

endmodule
